// File: sv/stereo_flanger_defines.svh
// assertion helpers shared by the flanger rtl
`ifndef STEREO_FLANGER_DEFINES_SVH
`define STEREO_FLANGER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SF_ASSERT_IMPL(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define SF_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: sv/sf_pkg.sv
`timescale 1ns / 1ps

package sf_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_DEPTH  = 3'd1;
   localparam logic [2:0] REG_STEP   = 3'd2;
   localparam logic [2:0] REG_MIN    = 3'd3;
   localparam logic [2:0] REG_SPAN   = 3'd4;

   // depth scaling for wet and feedback targets, q15
   localparam logic [14:0] WET_MAX_Q15 = 15'd22938;
   localparam logic [14:0] FB_MAX_Q15  = 15'd24576;

   // gain glide divides the distance by 64
   localparam int SMOOTH_SHIFT = 6;

   // frames held between front and back
   localparam int Q_DEPTH = 2;

   // lane multiplier operand selection
   localparam logic [1:0] MUL_INTERP = 2'd0;
   localparam logic [1:0] MUL_WET    = 2'd1;
   localparam logic [1:0] MUL_FB     = 2'd2;

   // per-cycle commands from the sequencer to both channel lanes
   typedef struct packed {
      logic       in_load;
      logic       byp_load;
      logic       rd_hit;
      logic       x0_load;
      logic       mul_load;
      logic [1:0] mul_sel;
      logic       dly_load;
      logic       res_load;
      logic       wr_en;
   } lane_ctl_type;

endpackage

// File: sv/sf_front.sv
`timescale 1ns / 1ps

module sf_front
   import sf_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   localparam int SW = SAMPLE_BITS,
   localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,
   output logic                 q_valid,
   output logic                 q_bypass,
   output logic signed [SW-1:0] q_left,
   output logic signed [SW-1:0] q_right,
   input  logic                 q_pop
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   logic                 byp_q   [Q_DEPTH];
   logic signed [SW-1:0] left_q  [Q_DEPTH];
   logic signed [SW-1:0] right_q [Q_DEPTH];

   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push;

   // accept while the queue has room
   assign req_tready = (cnt_ff != CW'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;

   // head of queue toward the back
   assign q_valid  = (cnt_ff != '0);
   assign q_bypass = byp_q[rd_ptr_ff];
   assign q_left   = left_q[rd_ptr_ff];
   assign q_right  = right_q[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // occupancy and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

   // classify at entry: a frame taken while disabled passes through
   always_ff @(posedge clock) begin
      if (push) begin
         byp_q[wr_ptr_ff]   <= !enable;
         left_q[wr_ptr_ff]  <= req_tdata[SW-1:0];
         right_q[wr_ptr_ff] <= req_tdata[2*SW-1:SW];
      end
   end

endmodule

// File: sv/sf_lane.sv
`timescale 1ns / 1ps

module sf_lane
   import sf_pkg::*;
#(
   parameter int LINE_DEPTH = 512,
   parameter int SAMPLE_BITS = 24,
   localparam int AW = $clog2(LINE_DEPTH),
   localparam int SW = SAMPLE_BITS
) (
   input  logic                 clock,
   input  lane_ctl_type         ctl,
   input  logic [AW-1:0]        rd_addr,
   input  logic [AW-1:0]        wr_addr,
   input  logic [15:0]          frac,
   input  logic [14:0]          wet_level,
   input  logic [14:0]          fb_gain,
   input  logic signed [SW-1:0] in_sample,
   output logic signed [SW-1:0] res
);

   localparam logic signed [SW+3:0] SAT_HI = {5'b00000, {(SW-1){1'b1}}};
   localparam logic signed [SW+3:0] SAT_LO = {5'b11111, {(SW-1){1'b0}}};

   function automatic logic signed [SW-1:0] sat(input logic signed [SW+3:0] v);
      logic signed [SW+3:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      sat = SW'(c);
   endfunction

   logic signed [SW-1:0] line_mem [LINE_DEPTH];

   logic signed [SW-1:0]  rd_ff, in_ff, x0_ff, dly_ff, res_ff;
   logic                  hit_ff;
   logic signed [SW+17:0] prod_ff, prod_in;
   logic signed [SW-1:0]  x_rd;
   logic signed [SW:0]    diff, mul_a;
   logic signed [16:0]    mul_b;
   logic signed [SW+1:0]  dly_in;
   logic signed [SW+3:0]  mix_sum;

   // entries not yet written since the last clear read as zero
   assign x_rd = hit_ff ? rd_ff : '0;
   assign diff = (SW + 1)'(x_rd) - (SW + 1)'(x0_ff);

   // one multiplier, used for interpolation then wet then feedback
   always_comb begin
      case (ctl.mul_sel)
         MUL_INTERP: begin
            mul_a = diff;
            mul_b = signed'({1'b0, frac});
         end
         MUL_WET: begin
            mul_a = (SW + 1)'(dly_ff);
            mul_b = signed'({2'b00, wet_level});
         end
         MUL_FB: begin
            mul_a = (SW + 1)'(dly_ff);
            mul_b = signed'({2'b00, fb_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // interpolated tap and mix sums with floor shifts
   assign dly_in  = (SW + 2)'(x0_ff) + (SW + 2)'(prod_ff >>> 16);
   assign mix_sum = (SW + 4)'(in_ff) + (SW + 4)'(prod_ff >>> 15);

   // delay line storage
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         line_mem[wr_addr] <= sat(mix_sum);
      end
      rd_ff  <= line_mem[rd_addr];
      hit_ff <= ctl.rd_hit;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctl.in_load) begin
         in_ff <= in_sample;
      end
      if (ctl.x0_load) begin
         x0_ff <= x_rd;
      end
      if (ctl.mul_load) begin
         prod_ff <= prod_in;
      end
      if (ctl.dly_load) begin
         dly_ff <= SW'(dly_in);
      end
      if (ctl.byp_load) begin
         res_ff <= in_sample;
      end else if (ctl.res_load) begin
         res_ff <= sat(mix_sum);
      end
   end

   assign res = res_ff;

endmodule

// File: sv/sf_seq.sv
`timescale 1ns / 1ps
`include "stereo_flanger_defines.svh"

module sf_seq
   import sf_pkg::*;
#(
   parameter int LINE_DEPTH = 512,
   localparam int AW = $clog2(LINE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic [14:0]   depth,
   input  logic [31:0]   lfo_step,
   input  logic [24:0]   min_delay,
   input  logic [24:0]   span_delay,
   input  logic          q_valid,
   input  logic          q_bypass,
   output logic          q_pop,
   input  logic          rsp_free,
   output logic          out_load,
   output lane_ctl_type  ctl,
   output logic [AW-1:0] rd_addr,
   output logic [AW-1:0] wr_addr,
   output logic [15:0]   frac,
   output logic [14:0]   wet_level,
   output logic [14:0]   fb_gain
);

   localparam int DMAX = LINE_DEPTH - 2;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LFO  = 4'd1;
   localparam logic [3:0] ST_DLY  = 4'd2;
   localparam logic [3:0] ST_ADR  = 4'd3;
   localparam logic [3:0] ST_RD1  = 4'd4;
   localparam logic [3:0] ST_INT  = 4'd5;
   localparam logic [3:0] ST_MIX  = 4'd6;
   localparam logic [3:0] ST_WET  = 4'd7;
   localparam logic [3:0] ST_FB   = 4'd8;
   localparam logic [3:0] ST_WB   = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   // glide one truncated 1/64 step toward target, at least one lsb
   function automatic logic [14:0] gain_step(input logic [14:0] now, input logic [14:0] tgt);
      logic signed [15:0] d;
      logic [15:0]        mag;
      logic [14:0]        s;
      d   = signed'({1'b0, tgt}) - signed'({1'b0, now});
      mag = d[15] ? 16'(-d) : 16'(d);
      s   = 15'(mag >> SMOOTH_SHIFT);
      if (s == '0 && d != '0) begin
         s = 15'd1;
      end
      gain_step = d[15] ? now - s : now + s;
   endfunction

   logic [3:0]    state_ff, state_in;
   logic [31:0]   phase_ff;
   logic [14:0]   wet_ff, fb_ff;
   logic [25:0]   delay_ff, delay_in;
   logic [AW-1:0] i0_ff, i0_in, i1, wp_ff, wp_in, dint;
   logic [AW:0]   fill_ff;
   logic [29:0]   wet_prod, fb_prod;
   logic [14:0]   wet_tgt, fb_tgt;
   logic [15:0]   tri_wave;
   logic [40:0]   span_prod;
   logic [9:0]    dint_raw;

   // gain targets from the depth knob
   assign wet_prod = 30'(depth) * 30'(WET_MAX_Q15);
   assign fb_prod  = 30'(depth) * 30'(FB_MAX_Q15);
   assign wet_tgt  = wet_prod[29:15];
   assign fb_tgt   = fb_prod[29:15];

   // triangle from the phase and the swept q10.16 delay
   assign tri_wave  = phase_ff[31] ? ~phase_ff[30:15] : phase_ff[30:15];
   assign span_prod = 41'(span_delay) * 41'(tri_wave);
   assign delay_in  = 26'(min_delay) + 26'(span_prod[40:16]);

   // integer delay clamp and tap addresses
   assign dint_raw = delay_ff[25:16];
   assign dint     = (32'(dint_raw) > 32'(DMAX)) ? AW'(DMAX) : AW'(dint_raw);

   always_comb begin
      if ((AW + 1)'(wp_ff) >= (AW + 1)'(dint)) begin
         i0_in = wp_ff - dint;
      end else begin
         i0_in = AW'((AW + 1)'(wp_ff) + (AW + 1)'(LINE_DEPTH) - (AW + 1)'(dint));
      end
   end

   assign i1    = (i0_ff == '0) ? AW'(LINE_DEPTH - 1) : i0_ff - AW'(1);
   assign wp_in = (wp_ff == AW'(LINE_DEPTH - 1)) ? '0 : wp_ff + AW'(1);

   assign rd_addr   = (state_ff == ST_RD1) ? i1 : i0_in;
   assign wr_addr   = wp_ff;
   assign frac      = delay_ff[15:0];
   assign wet_level = wet_ff;
   assign fb_gain   = fb_ff;

   // step sequencer
   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      ctl          = '0;
      ctl.mul_sel  = MUL_INTERP;
      ctl.rd_hit   = ((AW + 1)'(rd_addr) < fill_ff);
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               ctl.in_load = 1'b1;
               if (q_bypass) begin
                  ctl.byp_load = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  state_in = ST_LFO;
               end
            end
         end
         ST_LFO: state_in = ST_DLY;
         ST_DLY: state_in = ST_ADR;
         ST_ADR: state_in = ST_RD1;
         ST_RD1: begin
            ctl.x0_load = 1'b1;
            state_in    = ST_INT;
         end
         ST_INT: begin
            ctl.mul_load = 1'b1;
            ctl.mul_sel  = MUL_INTERP;
            state_in     = ST_MIX;
         end
         ST_MIX: begin
            ctl.dly_load = 1'b1;
            state_in     = ST_WET;
         end
         ST_WET: begin
            ctl.mul_load = 1'b1;
            ctl.mul_sel  = MUL_WET;
            state_in     = ST_FB;
         end
         ST_FB: begin
            ctl.res_load = 1'b1;
            ctl.mul_load = 1'b1;
            ctl.mul_sel  = MUL_FB;
            state_in     = ST_WB;
         end
         ST_WB: begin
            ctl.wr_en = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // effect state: phase, gains, write pointer, fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         wet_ff   <= '0;
         fb_ff    <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (clear) begin
            phase_ff <= '0;
            wet_ff   <= wet_tgt;
            fb_ff    <= fb_tgt;
            wp_ff    <= '0;
            fill_ff  <= '0;
         end else begin
            if (state_ff == ST_LFO) begin
               phase_ff <= phase_ff + lfo_step;
               wet_ff   <= gain_step(wet_ff, wet_tgt);
               fb_ff    <= gain_step(fb_ff, fb_tgt);
            end
            if (state_ff == ST_WB) begin
               wp_ff <= wp_in;
               if (fill_ff != (AW + 1)'(LINE_DEPTH)) begin
                  fill_ff <= fill_ff + (AW + 1)'(1);
               end
            end
         end
      end
   end

   // per-frame delay and first tap
   always_ff @(posedge clock) begin
      if (state_ff == ST_DLY) begin
         delay_ff <= delay_in;
      end
      if (state_ff == ST_ADR) begin
         i0_ff <= i0_in;
      end
   end

   `SF_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= (AW + 1)'(LINE_DEPTH), "fill count past line depth")
   `SF_ASSERT_IMPL(a_wp_bound, clock, reset, 1'b1, (AW + 1)'(wp_ff) < (AW + 1)'(LINE_DEPTH), "write pointer past line depth")
   `SF_ASSERT_IMPL(a_pop_ok, clock, reset, q_pop, q_valid && state_ff == ST_IDLE, "pop without a queued frame")
   `SF_ASSERT_NEXT(a_clear_rewinds, clock, reset, clear, wp_ff == '0 && fill_ff == '0, "clear did not rewind the lines")
   `SF_ASSERT_NEXT(a_write_then_out, clock, reset, ctl.wr_en, state_ff == ST_OUT, "write back not followed by output")

endmodule

// File: sv/stereo_flanger.sv
`timescale 1ns / 1ps

// Stereo flanger on signed two's complement frames (Q1.23 at 24 sample bits).
// Frames enter through a two-deep queue, so the input side keeps accepting
// while a result waits on the output register. A frame taken while disabled
// comes out unchanged, going from idle straight to the output state; an
// enabled frame is paced by the step sequencer: each delay line has one read
// port (two taps read on successive cycles) and each channel one multiplier
// that is used three times per frame (interpolation, wet, feedback), before
// the output handoff. Writing enable from 0 to 1 zeroes the LFO phase and
// write pointer, loads the gains at their targets and empties both lines at
// once through a fill count, so no clearing pass is needed. tdata packs left
// in the low bits, then right, zero padded to whole bytes.
module stereo_flanger
   import sf_pkg::*;
#(
   parameter int LINE_DEPTH = 512,
   parameter int SAMPLE_BITS = 24,
   localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   // transaction in: left_in, right_in
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   // transaction out: left_out, right_out
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int SW = SAMPLE_BITS;

   logic        enable_ff;
   logic [14:0] depth_ff;
   logic [31:0] step_ff;
   logic [24:0] min_ff, span_ff;
   logic        csr_write, clear;

   logic                 q_valid, q_bypass, q_pop;
   logic signed [SW-1:0] q_left, q_right, res_left, res_right;
   logic                 out_load, rsp_free;
   lane_ctl_type         ctl;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [15:0]          frac;
   logic [14:0]          wet_level, fb_gain;

   logic                 rsp_valid_ff;
   logic signed [SW-1:0] rsp_left_ff, rsp_right_ff;

   // register writes, always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign clear     = csr_write && (csr_index == REG_ENABLE) && csr_data[0] && !enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         depth_ff  <= '0;
         step_ff   <= '0;
         min_ff    <= '0;
         span_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ENABLE: enable_ff <= csr_data[0];
            REG_DEPTH:  depth_ff  <= csr_data[14:0];
            REG_STEP:   step_ff   <= csr_data;
            REG_MIN:    min_ff    <= csr_data[24:0];
            REG_SPAN:   span_ff   <= csr_data[24:0];
            default:    ;
         endcase
      end
   end

   // front: accept and classify
   sf_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_bypass   (q_bypass),
      .q_left     (q_left),
      .q_right    (q_right),
      .q_pop      (q_pop)
   );

   // back: sequencer and one lane per channel
   sf_seq #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .depth      (depth_ff),
      .lfo_step   (step_ff),
      .min_delay  (min_ff),
      .span_delay (span_ff),
      .q_valid    (q_valid),
      .q_bypass   (q_bypass),
      .q_pop      (q_pop),
      .rsp_free   (rsp_free),
      .out_load   (out_load),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .frac       (frac),
      .wet_level  (wet_level),
      .fb_gain    (fb_gain)
   );

   sf_lane #(
      .LINE_DEPTH(LINE_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_left (
      .clock     (clock),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .frac      (frac),
      .wet_level (wet_level),
      .fb_gain   (fb_gain),
      .in_sample (q_left),
      .res       (res_left)
   );

   sf_lane #(
      .LINE_DEPTH(LINE_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_right (
      .clock     (clock),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .frac      (frac),
      .wet_level (wet_level),
      .fb_gain   (fb_gain),
      .in_sample (q_right),
      .res       (res_right)
   );

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_left_ff  <= res_left;
         rsp_right_ff <= res_right;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({rsp_right_ff, rsp_left_ff});

endmodule
